// File: src/tes_pkg.sv
// ----------------------------------------------------------------------------
// Text encoding sniffer package
// Shared word types, byte classes and encoding codes of the sniffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

    localparam int OUT_COUNT_WIDTH = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_LE      = 3'd1;
    localparam logic [2:0] ENC_BE      = 3'd2;
    localparam logic [2:0] ENC_ASCII   = 3'd3;
    localparam logic [2:0] ENC_UNKNOWN = 3'd4;

    localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
    localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
    localparam logic [7:0] BOM_UTF8_2 = 8'hBF;
    localparam logic [7:0] BOM_FF     = 8'hFF;
    localparam logic [7:0] BOM_FE     = 8'hFE;

    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       empty_set;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                 encoding;
        logic [OUT_COUNT_WIDTH-1:0] sequence_total;
        logic [OUT_COUNT_WIDTH-1:0] ascii_total;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        byte_class_t cls;
        logic        has_byte;
        logic        ends;
    } queue_entry_t;

endpackage

`default_nettype wire

// File: src/text_encoding_sniffer.sv
// ----------------------------------------------------------------------------
// Text encoding sniffer
// Classifies the encoding of a byte buffer from its byte order mark or its
// UTF-8 sequences and reports the sequence and ASCII byte counts.
//
// Bytes enter on the byte channel, one word per cycle while byte_ready is
// high, in buffer order. A word with last_byte set closes the buffer after
// its byte; a word with empty_set set closes it without adding a byte. One
// result word leaves on the result channel for each closed buffer and none
// for other words. The front end classifies each byte and places it in a
// two-word queue; the scanner takes one word per cycle from the queue unless
// a closing word waits on a held result, so the sustained rate is one byte
// per cycle. A closing word is registered in the queue and its result then
// in the output register. While the result waits there, bytes of the next
// buffer keep flowing through the scanner, and only a second closing word
// waits in the queue, which then fills and lowers byte_ready.
// Reset clears the queue, the scan state and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_sniffer
    import tes_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_ready,
    input  wire in_word_t  byte_word,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_word_t      result_word
);

    logic          queue_full;
    logic          push;
    queue_entry_t  push_entry;
    logic          pop;
    logic          head_valid;
    queue_entry_t  head_entry;

    tes_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tes_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    tes_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

// File: src/tes_front.sv
// ----------------------------------------------------------------------------
// Sniffer front end
// Accepts input words and classifies each byte before it is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_front
    import tes_pkg::*;
(
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire in_word_t     byte_word,
    input  wire logic         queue_full,
    output logic              push,
    output queue_entry_t      push_entry
);

    byte_class_t cls;

    always_comb
    begin
        priority if (byte_word.byte_value[7] == 1'b0)
            cls = CLS_ASCII;
        else if ((byte_word.byte_value & MASK_CONT) == CODE_CONT)
            cls = CLS_CONT;
        else if ((byte_word.byte_value & MASK_LEAD2) == CODE_LEAD2)
            cls = CLS_LEAD2;
        else if ((byte_word.byte_value & MASK_LEAD3) == CODE_LEAD3)
            cls = CLS_LEAD3;
        else if ((byte_word.byte_value & MASK_LEAD4) == CODE_LEAD4)
            cls = CLS_LEAD4;
        else
            cls = CLS_OTHER;
    end

    assign byte_ready = !queue_full;
    assign push       = byte_valid && !queue_full;

    always_comb
    begin
        push_entry.byte_value = byte_word.byte_value;
        push_entry.cls        = cls;
        push_entry.has_byte   = !byte_word.empty_set;
        push_entry.ends       = byte_word.empty_set || byte_word.last_byte;
    end

endmodule

`default_nettype wire

// File: src/tes_queue.sv
// ----------------------------------------------------------------------------
// Sniffer queue
// Short first-in first-out queue between the front end and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_queue
    import tes_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire queue_entry_t  push_entry,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output queue_entry_t       head_entry
);

    localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

    queue_entry_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg;
    logic [PTR_WIDTH-1:0]  wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg;
    logic [PTR_WIDTH-1:0]  rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// File: src/tes_back.sv
// ----------------------------------------------------------------------------
// Sniffer scanner
// Tracks byte order marks and UTF-8 sequences and issues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_back
    import tes_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire queue_entry_t  head_entry,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_ready,
    output out_word_t          result_word
);

    localparam int EXT_WIDTH = COUNT_WIDTH + OUT_COUNT_WIDTH;

    logic                    pending_reg, pending_upd, pending_next;
    logic [1:0]              need_reg, need_upd, need_next;
    logic [1:0]              have_reg, have_upd, have_next;
    logic [1:0]              fill_reg, fill_upd, fill_next;
    logic                    high_reg, high_upd, high_next;
    logic [COUNT_WIDTH-1:0]  seq_reg, seq_upd, seq_next;
    logic [COUNT_WIDTH-1:0]  asc_reg, asc_upd, asc_next;
    logic [7:0]              fb_reg [3];
    logic [7:0]              fb_upd [3];
    logic                    res_valid_reg, res_valid_next;
    out_word_t               res_word_reg, res_word_next;
    logic [1:0]              have_inc;
    logic                    fresh;
    logic [EXT_WIDTH-1:0]    seq_ext;
    logic [EXT_WIDTH-1:0]    asc_ext;
    logic                    bom_utf8;
    logic                    bom_le;
    logic                    bom_be;

    assign pop = head_valid && (!head_entry.ends || !res_valid_reg || result_ready);
    assign have_inc = have_reg + 2'd1;

    always_comb
    begin
        pending_upd = pending_reg;
        need_upd    = need_reg;
        have_upd    = have_reg;
        fill_upd    = fill_reg;
        high_upd    = high_reg;
        seq_upd     = seq_reg;
        asc_upd     = asc_reg;
        fb_upd      = fb_reg;
        fresh       = 1'b0;
        if (head_entry.has_byte)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (fill_reg == 2'(i))
                    fb_upd[i] = head_entry.byte_value;
            end
            if (fill_reg != 2'd3)
                fill_upd = fill_reg + 2'd1;
            if (head_entry.byte_value[7])
                high_upd = 1'b1;
            if (head_entry.cls == CLS_ASCII && asc_reg != '1)
                asc_upd = asc_reg + 1'b1;
            if (pending_reg && head_entry.cls == CLS_CONT)
            begin
                if (have_inc == need_reg)
                begin
                    pending_upd = 1'b0;
                    if (seq_reg != '1)
                        seq_upd = seq_reg + 1'b1;
                end
                else
                begin
                    have_upd = have_inc;
                end
            end
            else
            begin
                pending_upd = 1'b0;
                fresh       = 1'b1;
            end
            if (fresh)
            begin
                unique case (head_entry.cls)
                    CLS_LEAD2:
                    begin
                        pending_upd = 1'b1;
                        need_upd    = 2'd1;
                        have_upd    = 2'd0;
                    end
                    CLS_LEAD3:
                    begin
                        pending_upd = 1'b1;
                        need_upd    = 2'd2;
                        have_upd    = 2'd0;
                    end
                    CLS_LEAD4:
                    begin
                        pending_upd = 1'b1;
                        need_upd    = 2'd3;
                        have_upd    = 2'd0;
                    end
                    default:
                    begin
                        pending_upd = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        seq_ext  = {{OUT_COUNT_WIDTH{1'b0}}, seq_upd};
        asc_ext  = {{OUT_COUNT_WIDTH{1'b0}}, asc_upd};
        bom_utf8 = (fill_upd == 2'd3) && (fb_upd[0] == BOM_UTF8_0)
                   && (fb_upd[1] == BOM_UTF8_1) && (fb_upd[2] == BOM_UTF8_2);
        bom_le   = (fill_upd >= 2'd2) && (fb_upd[0] == BOM_FF) && (fb_upd[1] == BOM_FE);
        bom_be   = (fill_upd >= 2'd2) && (fb_upd[0] == BOM_FE) && (fb_upd[1] == BOM_FF);
        res_word_next.sequence_total = '0;
        res_word_next.ascii_total    = '0;
        priority if (fill_upd == 2'd0)
            res_word_next.encoding = ENC_UTF8;
        else if (bom_utf8)
            res_word_next.encoding = ENC_UTF8;
        else if (bom_le)
            res_word_next.encoding = ENC_LE;
        else if (bom_be)
            res_word_next.encoding = ENC_BE;
        else
        begin
            res_word_next.sequence_total = seq_ext[OUT_COUNT_WIDTH-1:0];
            res_word_next.ascii_total    = asc_ext[OUT_COUNT_WIDTH-1:0];
            if (seq_upd != '0)
                res_word_next.encoding = ENC_UTF8;
            else if (!high_upd)
                res_word_next.encoding = ENC_ASCII;
            else
                res_word_next.encoding = ENC_UNKNOWN;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        need_next    = need_reg;
        have_next    = have_reg;
        fill_next    = fill_reg;
        high_next    = high_reg;
        seq_next     = seq_reg;
        asc_next     = asc_reg;
        if (pop)
        begin
            if (head_entry.ends)
            begin
                pending_next = 1'b0;
                need_next    = 2'd0;
                have_next    = 2'd0;
                fill_next    = 2'd0;
                high_next    = 1'b0;
                seq_next     = '0;
                asc_next     = '0;
            end
            else
            begin
                pending_next = pending_upd;
                need_next    = need_upd;
                have_next    = have_upd;
                fill_next    = fill_upd;
                high_next    = high_upd;
                seq_next     = seq_upd;
                asc_next     = asc_upd;
            end
        end
        if (pop && head_entry.ends)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            need_reg      <= 2'd0;
            have_reg      <= 2'd0;
            fill_reg      <= 2'd0;
            high_reg      <= 1'b0;
            seq_reg       <= '0;
            asc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            need_reg      <= need_next;
            have_reg      <= have_next;
            fill_reg      <= fill_next;
            high_reg      <= high_next;
            seq_reg       <= seq_next;
            asc_reg       <= asc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head_entry.ends)
            fb_reg <= fb_upd;
        if (pop && head_entry.ends)
            res_word_reg <= res_word_next;
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;

endmodule

`default_nettype wire

// File: src/text_encoding_sniffer_checker.sv
// ----------------------------------------------------------------------------
// Text encoding sniffer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_sniffer_checker
    import tes_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      result_valid,
    input  wire logic      result_ready,
    input  wire out_word_t result_word
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("Result word changed while stalled.");

    a_encoding_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.encoding <= ENC_UNKNOWN)
        else $error("Result encoding out of range.");

    a_utf16_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.encoding == ENC_LE || result_word.encoding == ENC_BE)
        |-> result_word.sequence_total == '0 && result_word.ascii_total == '0)
        else $error("UTF-16 result carries non-zero counts.");

    a_no_seq_not_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.encoding == ENC_ASCII
                         || result_word.encoding == ENC_UNKNOWN)
        |-> result_word.sequence_total == '0)
        else $error("Non-UTF-8 result reports sequences.");

endmodule

bind text_encoding_sniffer text_encoding_sniffer_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
);

`default_nettype wire

// File: tb/sv/tes_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text encoding sniffer checker
// Watches the byte and result channels of the sniffer. It keeps its own model
// of the lookahead scan and the byte order mark detection, predicts the result
// word of each closed buffer and compares every accepted result word with the
// oldest prediction.
// ----------------------------------------------------------------------------

module tes_checker
    import tes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    input  logic      byte_ready,
    input  in_word_t  byte_word,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_word_t result_word,
    output int        fail_count,
    output int        pending
);

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;

    logic [7:0]  window [3];
    int unsigned window_fill;
    logic [7:0]  head_bytes [3];
    logic [31:0] byte_cnt;
    logic [31:0] seq_cnt;
    logic [31:0] ascii_cnt;
    logic        high_seen;

    out_word_t   verdict_q [$];

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == COUNT_TOP) ? v : v + 32'd1;
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < 3; i++)
        begin
            window[i]     = 8'h00;
            head_bytes[i] = 8'h00;
        end
        window_fill = 0;
        byte_cnt    = '0;
        seq_cnt     = '0;
        ascii_cnt   = '0;
        high_seen   = 1'b0;
    endfunction

    // Bytes taken from the front of the window at pos; zero means wait for more.
    function automatic int unsigned lead_take(input logic [31:0] q, input int unsigned pos,
                                              input int unsigned left, input bit at_end);
        logic [7:0]  c;
        int unsigned need;
        int unsigned k;
        c = q[8*pos +: 8];
        if (c < ASCII_LIMIT)
        begin
            ascii_cnt = bump(ascii_cnt);
            return 1;
        end
        if ((c & MASK_LEAD2) == CODE_LEAD2)
            need = 1;
        else if ((c & MASK_LEAD3) == CODE_LEAD3)
            need = 2;
        else if ((c & MASK_LEAD4) == CODE_LEAD4)
            need = 3;
        else
            return 1;
        for (k = 1; k <= need; k++)
        begin
            if (k >= left)
                return at_end ? 1 : 0;
            if ((q[8*(pos+k) +: 8] & MASK_CONT) != CODE_CONT)
                return 1;
        end
        seq_cnt = bump(seq_cnt);
        return need + 1;
    endfunction

    function automatic void scan(input bit with_byte, input logic [7:0] b, input bit at_end);
        logic [31:0] q;
        int unsigned n;
        int unsigned pos;
        int unsigned used;
        int unsigned i;
        q = '0;
        n = window_fill;
        for (i = 0; i < n; i++)
            q[8*i +: 8] = window[i];
        if (with_byte)
        begin
            q[8*n +: 8] = b;
            n++;
        end
        pos = 0;
        while (pos < n)
        begin
            used = lead_take(q, pos, n - pos, at_end);
            if (used == 0)
                break;
            pos += used;
        end
        for (i = 0; i < 3; i++)
            window[i] = 8'h00;
        window_fill = 0;
        for (i = pos; i < n && window_fill < 3; i++)
        begin
            window[window_fill] = q[8*i +: 8];
            window_fill++;
        end
    endfunction

    function automatic out_word_t close_buffer();
        out_word_t r;
        scan(1'b0, 8'h00, 1'b1);
        r.sequence_total = seq_cnt;
        r.ascii_total    = ascii_cnt;
        if (byte_cnt == 0)
        begin
            r.encoding       = ENC_UTF8;
            r.sequence_total = '0;
            r.ascii_total    = '0;
        end
        else if (byte_cnt >= 3 && head_bytes[0] == BOM_UTF8_0 &&
                 head_bytes[1] == BOM_UTF8_1 && head_bytes[2] == BOM_UTF8_2)
        begin
            r.encoding       = ENC_UTF8;
            r.sequence_total = '0;
            r.ascii_total    = '0;
        end
        else if (byte_cnt >= 2 && head_bytes[0] == BOM_FF && head_bytes[1] == BOM_FE)
        begin
            r.encoding       = ENC_LE;
            r.sequence_total = '0;
            r.ascii_total    = '0;
        end
        else if (byte_cnt >= 2 && head_bytes[0] == BOM_FE && head_bytes[1] == BOM_FF)
        begin
            r.encoding       = ENC_BE;
            r.sequence_total = '0;
            r.ascii_total    = '0;
        end
        else if (seq_cnt != 0)
            r.encoding = ENC_UTF8;
        else if (!high_seen)
            r.encoding = ENC_ASCII;
        else
            r.encoding = ENC_UNKNOWN;
        clear_scan();
        return r;
    endfunction

    function automatic void sniff_word(input in_word_t w);
        if (w.empty_set)
            verdict_q.push_back(close_buffer());
        else
        begin
            if (byte_cnt < 3)
                head_bytes[byte_cnt] = w.byte_value;
            byte_cnt = bump(byte_cnt);
            if (w.byte_value >= ASCII_LIMIT)
                high_seen = 1'b1;
            scan(1'b1, w.byte_value, 1'b0);
            if (w.last_byte)
                verdict_q.push_back(close_buffer());
        end
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s expected %0h, got %0h", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            clear_scan();
            verdict_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                    flag("unexpected result word, encoding", '0,
                         32'(result_word.encoding));
                else
                begin
                    want = verdict_q.pop_front();
                    if (result_word.encoding !== want.encoding)
                        flag("encoding", 32'(want.encoding), 32'(result_word.encoding));
                    if (result_word.sequence_total !== want.sequence_total)
                        flag("sequence_total", want.sequence_total,
                             result_word.sequence_total);
                    if (result_word.ascii_total !== want.ascii_total)
                        flag("ascii_total", want.ascii_total, result_word.ascii_total);
                end
            end
            if (byte_valid && byte_ready)
                sniff_word(byte_word);
            pending = verdict_q.size();
        end
    end

endmodule

// File: tb/sv/tb_text_encoding_sniffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text encoding sniffer testbench
// Drives buffers of bytes into the sniffer: a directed set covering the byte
// order marks, each UTF-8 sequence length, truncated and broken sequences and
// empty buffers, then random buffers of mostly well-formed text with broken
// and noisy ones mixed in. Both channels idle at random; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module tb_text_encoding_sniffer;
    import tes_pkg::*;

    localparam int ITEMS       = 1900;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    in_word_t    byte_word;
    logic        result_valid;
    logic        result_ready;
    out_word_t   result_word;
    int          fail_count;
    int          pending;

    int unsigned cycle_cnt = 0;
    int unsigned item_cnt  = 0;
    int unsigned burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    logic [7:0]  text_bytes [$];

    text_encoding_sniffer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    tes_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT)
        begin
            $display("tb_text_encoding_sniffer: done, errors");
            $finish;
        end
    end

    initial
    begin : receiver
        int unsigned phase;
        int unsigned mode;
        phase = 0;
        mode  = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                phase++;
                if (phase % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= (phase % 4 != 3);
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input in_word_t w);
        int unsigned gap;
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_word  <= w;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        item_cnt++;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                byte_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                          : $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_empty();
        in_word_t w;
        w.byte_value = 8'($urandom_range(0, 255));
        w.last_byte  = 1'($urandom_range(0, 1));
        w.empty_set  = 1'b1;
        send_word(w);
    endtask

    task automatic send_text(input bit via_empty, input bit noisy);
        in_word_t w;
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            w.byte_value = text_bytes[i];
            w.empty_set  = 1'b0;
            w.last_byte  = (i == text_bytes.size() - 1 && !via_empty) ||
                           (noisy && $urandom_range(0, 5) == 0);
            send_word(w);
        end
        if (via_empty)
            send_empty();
    endtask

    task automatic drain();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic push_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            text_bytes.push_back(8'($urandom_range(0, 127)));
        else if (pick < 6)
        begin
            text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            text_bytes.push_back(cont_byte());
        end
        else if (pick < 8)
        begin
            text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            repeat (2) text_bytes.push_back(cont_byte());
        end
        else
        begin
            text_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) text_bytes.push_back(cont_byte());
        end
    endtask

    function automatic logic [7:0] lead_byte();
        case ($urandom_range(0, 2))
            0: return 8'hC0 | 8'($urandom_range(0, 31));
            1: return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic push_broken();
        case ($urandom_range(0, 3))
            0:
            begin
                text_bytes.push_back(lead_byte());
                text_bytes.push_back(8'($urandom_range(0, 127)));
            end
            1: text_bytes.push_back(cont_byte());
            2:
            begin
                text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 31)));
                text_bytes.push_back(cont_byte());
                text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            end
            default: text_bytes.push_back(8'hF8 | 8'($urandom_range(0, 7)));
        endcase
    endtask

    task automatic send_buffer();
        int unsigned kind;
        int unsigned n;
        bit          via_empty;
        bit          noisy;
        text_bytes.delete();
        kind      = $urandom_range(0, 15);
        via_empty = ($urandom_range(0, 7) == 0);
        noisy     = 1'b0;
        case (kind)
            0, 1, 2, 3, 4, 5, 6:
            begin
                n = $urandom_range(1, 8);
                repeat (n) push_char();
            end
            7:
            begin
                text_bytes = '{BOM_UTF8_0, BOM_UTF8_1, BOM_UTF8_2};
                n = $urandom_range(0, 5);
                repeat (n) push_char();
            end
            8, 9:
            begin
                if (kind == 8)
                    text_bytes = '{BOM_FF, BOM_FE};
                else
                    text_bytes = '{BOM_FE, BOM_FF};
                n = $urandom_range(0, 6);
                repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            10, 11:
            begin
                n = $urandom_range(1, 10);
                repeat (n) text_bytes.push_back(8'($urandom_range(0, 127)));
            end
            12:
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_char();
                    else
                        push_broken();
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    text_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                    n = $urandom_range(0, 2);
                    repeat (n) text_bytes.push_back(cont_byte());
                end
            end
            13:
            begin
                noisy = 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            15:
            begin
                n = $urandom_range(20, 60);
                repeat (n) push_char();
            end
            default: ;
        endcase
        if (text_bytes.size() == 0)
            send_empty();
        else
            send_text(via_empty, noisy);
    endtask

    initial
    begin
        int unsigned n;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_word  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_empty();
        text_bytes = '{BOM_UTF8_0, BOM_UTF8_1, BOM_UTF8_2, 8'h41};
        send_text(1'b0, 1'b0);
        text_bytes = '{BOM_FF, BOM_FE};
        send_text(1'b0, 1'b0);
        text_bytes = '{BOM_FE, BOM_FF, 8'h00};
        send_text(1'b0, 1'b0);
        text_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text(1'b0, 1'b0);
        text_bytes = '{8'hF0, 8'h9F};
        send_text(1'b1, 1'b0);
        send_word('{byte_value: 8'h80, last_byte: 1'b1, empty_set: 1'b1});
        text_bytes = '{8'hFF};
        send_text(1'b0, 1'b0);
        text_bytes = '{8'h7F};
        send_text(1'b0, 1'b0);
        drain();

        for (int round = 0; item_cnt < ITEMS; round++)
        begin
            if (round == 30)
            begin
                no_gaps      = 1'b1;
                hold_request = 1'b1;
                repeat (40)
                begin
                    text_bytes.delete();
                    n = $urandom_range(1, 3);
                    repeat (n) push_char();
                    send_text(1'b0, 1'b0);
                end
                no_gaps = 1'b0;
            end
            if (round == 90)
                drain();
            send_buffer();
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_text_encoding_sniffer: done, clean");
        else
            $display("tb_text_encoding_sniffer: done, errors");
        $finish;
    end

endmodule
